// ----- hdl/assert_macros.svh -----
// Assertion macros for the connection tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/tcst_pkg.sv -----
// ----------------------------------------------------------------------------
// tcst_pkg
// Types, constants and lookup functions of the TCP connection tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package tcst_pkg;

    localparam int FLOWS_DEF     = 1024;
    localparam int ACK_SLACK_DEF = 66000;

    localparam logic [1:0] VERDICT_CHANGE = 2'd0;
    localparam logic [1:0] VERDICT_SAME   = 2'd1;
    localparam logic [1:0] VERDICT_DROP   = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NEED_SYN = 3'd1;
    localparam logic [2:0] ERR_BAD_TRAN = 3'd2;
    localparam logic [2:0] ERR_WINDOW   = 3'd3;
    localparam logic [2:0] ERR_INVALID  = 3'd4;

    localparam logic [0:0] REG_STRICT   = 1'd0;
    localparam logic [0:0] REG_RST_ORD  = 1'd1;

    localparam logic [7:0] FL_FIN  = 8'h01;
    localparam logic [7:0] FL_SYN  = 8'h02;
    localparam logic [7:0] FL_RST  = 8'h04;
    localparam logic [7:0] FL_ACK  = 8'h10;
    localparam logic [7:0] FL_CORE = 8'h17;

    localparam logic [63:0] CASE_MAP = 64'h0005024300050140;

    // connection states, T_ER / T_OK are table-only codes
    localparam logic [3:0] S_NO = 4'd0;
    localparam logic [3:0] S_SS = 4'd1;
    localparam logic [3:0] S_S2 = 4'd2;
    localparam logic [3:0] S_SR = 4'd3;
    localparam logic [3:0] S_ES = 4'd4;
    localparam logic [3:0] S_FS = 4'd5;
    localparam logic [3:0] S_FR = 4'd6;
    localparam logic [3:0] S_CW = 4'd7;
    localparam logic [3:0] S_FW = 4'd8;
    localparam logic [3:0] S_CL = 4'd9;
    localparam logic [3:0] S_LA = 4'd10;
    localparam logic [3:0] S_TW = 4'd11;
    localparam logic [3:0] S_CD = 4'd12;
    localparam logic [3:0] S_RR = 4'd13;
    localparam logic [3:0] T_ER = 4'd14;
    localparam logic [3:0] T_OK = 4'd15;

    typedef struct packed {
        logic [9:0]  flow_index;
        logic        direction;
        logic [7:0]  flag_byte;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] window_field;
        logic [15:0] payload_length;
        logic [3:0]  window_scale;
    } seg_in_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] state_after;
        logic [2:0] error_code;
    } seg_out_t;

    // per-side window record
    typedef struct packed {
        logic [31:0] seq_end;
        logic [31:0] ack_win;
        logic [31:0] max_win;
        logic [3:0]  shift;
    } side_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_OUT
    } fsm_t;

    // transition table: state, direction, flag case
    function automatic logic [3:0] next_state(input logic [3:0] st, input logic dir,
                                              input logic [2:0] fc);
        logic [3:0] r;
        r = T_OK;
        case (st)
            S_NO: if (!dir)
                begin
                    case (fc)
                        3'd0: r = T_ER;
                        3'd1: r = S_SS;
                        3'd2: r = S_SR;
                        3'd3: r = S_ES;
                        3'd4: r = S_FS;
                        3'd5: r = S_CD;
                        default: r = T_OK;
                    endcase
                end
            S_SS:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (dir && fc == 3'd1) r = S_S2;
                    else if (dir && fc == 3'd2) r = S_SR;
                end
            S_S2:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (fc == 3'd2) r = S_SR;
                    else if (dir && fc == 3'd4) r = S_FR;
                end
            S_SR:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (!dir && fc == 3'd3) r = S_ES;
                    else if (fc == 3'd4) r = dir ? S_FR : S_FS;
                end
            S_ES:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (fc == 3'd4) r = dir ? S_FR : S_FS;
                end
            S_FS:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (dir && fc == 3'd3) r = S_FW;
                    else if (dir && fc == 3'd4) r = S_CL;
                end
            S_FR:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (!dir && fc == 3'd3) r = S_CW;
                    else if (!dir && fc == 3'd4) r = S_CL;
                end
            S_CW, S_FW:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (fc == 3'd4) r = S_LA;
                end
            S_CL:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (fc == 3'd3) r = S_LA;
                end
            S_LA:
                begin
                    if (fc == 3'd5) r = S_RR;
                    else if (fc == 3'd3) r = S_TW;
                end
            S_TW: if (!dir && fc == 3'd1) r = S_SS;
            default: r = T_OK;
        endcase
        return r;
    endfunction

    // strict mode forbidden-state masks
    function automatic logic [13:0] strict_bad(input logic dir, input logic [2:0] fc);
        logic [13:0] m;
        m = '0;
        case ({dir, fc})
            4'b0000: m = 14'h3FFF;
            4'b0010: m = 14'h0F93;
            4'b0011: m = 14'h0007;
            4'b0100: m = 14'h0007;
            4'b1000: m = 14'h3FFF;
            4'b1001: m = 14'h0F99;
            4'b1010: m = 14'h0001;
            4'b1011: m = 14'h0001;
            4'b1100: m = 14'h0007;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tcp_connection_state_tracker_top.sv -----
// ----------------------------------------------------------------------------
// tcp_connection_state_tracker_top
// Per-flow TCP state tracker with sequence/acknowledge window check.
// ----------------------------------------------------------------------------
// One segment is in flight at a time: the state and window memories are read
// at the transfer edge (synchronous read), the next cycle evaluates the
// segment and writes back, and the result register is offered the cycle
// after that. The next segment is taken in the cycle the result is
// transferred, so a new segment is never taken before the last result has
// left; a stalled result holds the input off for as long as the stall lasts.
// After reset a clearing pass walks all FLOWS entries (one flow with both
// sides per cycle) before the first segment is taken.
`default_nettype none
`include "assert_macros.svh"
module tcp_connection_state_tracker_top #(
    parameter int FLOWS     = tcst_pkg::FLOWS_DEF,
    parameter int ACK_SLACK = tcst_pkg::ACK_SLACK_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [0:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire tcst_pkg::seg_in_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output tcst_pkg::seg_out_t      out_data
);

    localparam int FW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    // configuration
    logic strict_reg, rst_ord_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg  <= 1'b0;
            rst_ord_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tcst_pkg::REG_STRICT)  strict_reg  <= cfg_data[0];
            if (cfg_index == tcst_pkg::REG_RST_ORD) rst_ord_reg <= cfg_data[0];
        end
    end

    // control
    tcst_pkg::fsm_t state_reg, state_next;
    logic [FW-1:0] clr_reg;
    logic          in_xfer;
    logic          out_xfer;
    logic          clr_done;

    assign clr_done = (clr_reg == FW'(FLOWS - 1));
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcst_pkg::ST_CLEAR: if (clr_done) state_next = tcst_pkg::ST_IDLE;
            tcst_pkg::ST_IDLE:  if (in_xfer) state_next = tcst_pkg::ST_READ;
            tcst_pkg::ST_READ:  state_next = tcst_pkg::ST_OUT;
            tcst_pkg::ST_OUT:   if (out_xfer) state_next = in_xfer ? tcst_pkg::ST_READ
                                                                   : tcst_pkg::ST_IDLE;
            default:            state_next = tcst_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            tcst_pkg::ST_IDLE: in_stall = 1'b0;
            tcst_pkg::ST_OUT:
                begin
                    out_valid = 1'b1;
                    in_stall  = out_stall;
                end
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcst_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tcst_pkg::ST_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    // captured segment and its reduced flow index
    tcst_pkg::seg_in_t seg_reg;
    logic [FW-1:0]     flow_reg;
    logic [FW-1:0]     flow_w;
    always_comb
    begin
        flow_w = FW'(32'(in_data.flow_index) % FLOWS);
    end
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            seg_reg  <= in_data;
            flow_reg <= flow_w;
        end
    end

    // memories: connection state per flow, window record per flow and side
    logic [3:0]            st_mem [FLOWS];
    tcst_pkg::side_t       side0_mem [FLOWS];
    tcst_pkg::side_t       side1_mem [FLOWS];
    logic [3:0]            st_rd_reg;
    tcst_pkg::side_t       s0_rd_reg, s1_rd_reg;
    logic                  wr_en;
    logic [FW-1:0]         wr_addr;
    logic [3:0]            st_wr;
    tcst_pkg::side_t       s0_wr, s1_wr;
    logic                  st_we;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            st_rd_reg <= st_mem[flow_w];
            s0_rd_reg <= side0_mem[flow_w];
            s1_rd_reg <= side1_mem[flow_w];
        end
        if (state_reg == tcst_pkg::ST_CLEAR)
        begin
            st_mem[clr_reg]    <= '0;
            side0_mem[clr_reg] <= '0;
            side1_mem[clr_reg] <= '0;
        end
        else if (wr_en)
        begin
            if (st_we) st_mem[wr_addr] <= st_wr;
            side0_mem[wr_addr] <= s0_wr;
            side1_mem[wr_addr] <= s1_wr;
        end
    end

    // segment evaluation (read-modify-write in ST_READ)
    logic [3:0]      st_c, nx;
    logic [2:0]      fc;
    logic [3:0]      idx;
    logic [7:0]      fl;
    logic            dir;
    tcst_pkg::side_t f, t;
    logic            wok;
    logic [31:0]     seq, ack, win, wend, skew;
    logic [3:0]      opt;
    logic [47:0]     slack_hi;
    logic [13:0]     bad_mask;
    tcst_pkg::seg_out_t res;
    logic            touch;

    always_comb
    begin
        fl   = seg_reg.flag_byte;
        dir  = seg_reg.direction;
        st_c = (st_rd_reg > tcst_pkg::S_RR) ? tcst_pkg::S_NO : st_rd_reg;
        idx  = {fl[4], fl[2:0]};
        fc   = 3'(tcst_pkg::CASE_MAP >> {idx, 2'b00});
        if (fc > 3'd5) fc = 3'd0;
        nx   = tcst_pkg::next_state(st_c, dir, fc);
        bad_mask = tcst_pkg::strict_bad(dir, fc);
        f    = dir ? s1_rd_reg : s0_rd_reg;
        t    = dir ? s0_rd_reg : s1_rd_reg;
        opt  = (seg_reg.window_scale > 4'd14) ? 4'd14 : seg_reg.window_scale;
        seq  = seg_reg.seq_number;
        ack  = seg_reg.ack_number;
        wend = seq + 32'(seg_reg.payload_length) + 32'(fl[1]) + 32'(fl[0]);
        win  = (seg_reg.window_field != 16'd0)
             ? (32'(seg_reg.window_field) << f.shift) : 32'd1;
        skew = '0;
        slack_hi = '0;
        wok  = 1'b1;
        if ((fl & tcst_pkg::FL_CORE) == tcst_pkg::FL_SYN)
        begin
            f = '{seq_end: wend, ack_win: wend, max_win: win, shift: opt};
            t = '{seq_end: 32'd0, ack_win: 32'd0, max_win: 32'd1, shift: 4'd0};
        end
        else if (((fl & tcst_pkg::FL_CORE) == (tcst_pkg::FL_SYN | tcst_pkg::FL_ACK))
                 && t.seq_end == 32'd0)
        begin
            wok = 1'b1;
        end
        else
        begin
            if ((fl & tcst_pkg::FL_CORE) == (tcst_pkg::FL_SYN | tcst_pkg::FL_ACK))
            begin
                f = '{seq_end: wend, ack_win: wend + 32'd1, max_win: win, shift: opt};
            end
            if (f.seq_end != 32'd0 && t.seq_end != 32'd0)
            begin
                if (!fl[4] || (fl[2] && ack == 32'd0)) ack = t.seq_end;
                if (fl[2] && seq == 32'd0 && st_c == tcst_pkg::S_SS)
                begin
                    wend = f.seq_end;
                    seq  = wend;
                end
                skew     = t.seq_end - ack;
                slack_hi = 48'(ACK_SLACK) << f.shift;
                if (fl[2] && rst_ord_reg && (f.seq_end - seq) > 32'd1) wok = 1'b0;
                else if (!((wend == f.ack_win) || (wend - f.ack_win) >> 31 != 32'd0))
                    wok = 1'b0;
                else if (((seq - (f.seq_end - t.max_win)) >> 31) != 32'd0) wok = 1'b0;
                else if (skew[31] && (32'd0 - skew) > 32'(ACK_SLACK)) wok = 1'b0;
                else if (!skew[31] && 48'(skew) > slack_hi) wok = 1'b0;
                else
                begin
                    if (skew[31]) t.seq_end = ack;
                    if (f.max_win < win) f.max_win = win;
                    if (wend != f.seq_end && ((wend - f.seq_end) >> 31) == 32'd0)
                        f.seq_end = wend;
                    if ((((ack + win) - t.ack_win) >> 31) == 32'd0) t.ack_win = ack + win;
                end
            end
        end

        // verdict
        res   = '{verdict: tcst_pkg::VERDICT_SAME, state_after: st_c,
                  error_code: tcst_pkg::ERR_NONE};
        touch = 1'b1;
        st_we = 1'b0;
        if (strict_reg && st_c == tcst_pkg::S_NO
            && (fl & tcst_pkg::FL_CORE) != tcst_pkg::FL_SYN && !fl[2])
        begin
            res.verdict = tcst_pkg::VERDICT_DROP; res.error_code = tcst_pkg::ERR_NEED_SYN;
            touch = 1'b0;
        end
        else if (strict_reg && bad_mask[st_c])
        begin
            res.verdict = tcst_pkg::VERDICT_DROP; res.error_code = tcst_pkg::ERR_BAD_TRAN;
            touch = 1'b0;
        end
        else if (!wok)
        begin
            res.verdict = tcst_pkg::VERDICT_DROP; res.error_code = tcst_pkg::ERR_WINDOW;
        end
        else if (nx == tcst_pkg::T_ER)
        begin
            res.verdict = tcst_pkg::VERDICT_DROP; res.error_code = tcst_pkg::ERR_INVALID;
        end
        else if (nx != tcst_pkg::T_OK)
        begin
            res.verdict = tcst_pkg::VERDICT_CHANGE; res.state_after = nx;
            st_we = 1'b1;
        end

        // SYN-ACK init is kept even on a window drop; f/t already hold it
        wr_en   = (state_reg == tcst_pkg::ST_READ) && touch;
        wr_addr = flow_reg;
        st_wr   = nx;
        s0_wr   = dir ? t : f;
        s1_wr   = dir ? f : t;
    end

    // result register
    tcst_pkg::seg_out_t out_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == tcst_pkg::ST_READ) out_reg <= res;
    end
    assign out_data = out_reg;

    // assertions
    `ASSERT_NEVER(a_no_out_in_read, clk, rst_n,
        out_valid && state_reg != tcst_pkg::ST_OUT, "result offered outside output state")
    `ASSERT_CLK(a_read_to_out, clk, rst_n,
        state_reg == tcst_pkg::ST_READ |=> out_valid, "result not offered after evaluation")
    `ASSERT_NEVER(a_no_take_clear, clk, rst_n,
        in_xfer && state_reg == tcst_pkg::ST_CLEAR, "segment taken during clearing pass")
    `ASSERT_NEVER(a_drop_code, clk, rst_n,
        out_valid && out_data.verdict != tcst_pkg::VERDICT_DROP
        && out_data.error_code != tcst_pkg::ERR_NONE, "error code on pass verdict")

endmodule
`default_nettype wire

// ----- sim/tcp_connection_state_tracker_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_connection_state_tracker_top_test
// Drives TCP segments through the connection tracker and checks every verdict,
// state and error code against a predictor of the state table and the
// sequence/acknowledge window, over several strictness settings and idling
// patterns. Stimulus is mostly well-formed connections with random content.
// ----------------------------------------------------------------------------
module tcp_connection_state_tracker_top_test;

    typedef tcst_pkg::seg_in_t  seg_in_t;
    typedef tcst_pkg::seg_out_t seg_out_t;

    localparam int FLOWS      = tcst_pkg::FLOWS_DEF;
    localparam int ACK_SLACK  = tcst_pkg::ACK_SLACK_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int POOL       = 32;
    localparam int PHASE_SEGS = 340;

    // package codes used by the predictor
    localparam logic [7:0]  FL_FIN   = tcst_pkg::FL_FIN;
    localparam logic [7:0]  FL_SYN   = tcst_pkg::FL_SYN;
    localparam logic [7:0]  FL_RST   = tcst_pkg::FL_RST;
    localparam logic [7:0]  FL_ACK   = tcst_pkg::FL_ACK;
    localparam logic [7:0]  FL_CORE  = tcst_pkg::FL_CORE;
    localparam logic [63:0] CASE_MAP = tcst_pkg::CASE_MAP;

    localparam logic [1:0] VERDICT_CHANGE = tcst_pkg::VERDICT_CHANGE;
    localparam logic [1:0] VERDICT_SAME   = tcst_pkg::VERDICT_SAME;
    localparam logic [1:0] VERDICT_DROP   = tcst_pkg::VERDICT_DROP;
    localparam logic [2:0] ERR_NONE       = tcst_pkg::ERR_NONE;
    localparam logic [2:0] ERR_NEED_SYN   = tcst_pkg::ERR_NEED_SYN;
    localparam logic [2:0] ERR_BAD_TRAN   = tcst_pkg::ERR_BAD_TRAN;
    localparam logic [2:0] ERR_WINDOW     = tcst_pkg::ERR_WINDOW;
    localparam logic [2:0] ERR_INVALID    = tcst_pkg::ERR_INVALID;
    localparam logic [0:0] REG_STRICT     = tcst_pkg::REG_STRICT;
    localparam logic [0:0] REG_RST_ORD    = tcst_pkg::REG_RST_ORD;

    localparam logic [3:0] S_NO = tcst_pkg::S_NO;
    localparam logic [3:0] S_SS = tcst_pkg::S_SS;
    localparam logic [3:0] S_S2 = tcst_pkg::S_S2;
    localparam logic [3:0] S_SR = tcst_pkg::S_SR;
    localparam logic [3:0] S_ES = tcst_pkg::S_ES;
    localparam logic [3:0] S_FS = tcst_pkg::S_FS;
    localparam logic [3:0] S_FR = tcst_pkg::S_FR;
    localparam logic [3:0] S_CW = tcst_pkg::S_CW;
    localparam logic [3:0] S_FW = tcst_pkg::S_FW;
    localparam logic [3:0] S_CL = tcst_pkg::S_CL;
    localparam logic [3:0] S_LA = tcst_pkg::S_LA;
    localparam logic [3:0] S_TW = tcst_pkg::S_TW;
    localparam logic [3:0] S_CD = tcst_pkg::S_CD;
    localparam logic [3:0] S_RR = tcst_pkg::S_RR;
    localparam logic [3:0] T_ER = tcst_pkg::T_ER;
    localparam logic [3:0] T_OK = tcst_pkg::T_OK;

    // flag cases
    localparam logic [2:0] FC_INV = 3'd0;
    localparam logic [2:0] FC_SYN = 3'd1;
    localparam logic [2:0] FC_SA  = 3'd2;
    localparam logic [2:0] FC_ACK = 3'd3;
    localparam logic [2:0] FC_FIN = 3'd4;
    localparam logic [2:0] FC_RST = 3'd5;

    // next state per [state][direction][flag case]
    localparam logic [3:0] NEXT_TAB [14][2][6] = '{
        '{'{T_ER, S_SS, S_SR, S_ES, S_FS, S_CD}, '{T_OK, T_OK, T_OK, T_OK, T_OK, T_OK}},
        '{'{T_OK, T_OK, T_OK, T_OK, T_OK, S_RR}, '{T_OK, S_S2, S_SR, T_OK, T_OK, S_RR}},
        '{'{T_OK, T_OK, S_SR, T_OK, T_OK, S_RR}, '{T_OK, T_OK, S_SR, T_OK, S_FR, S_RR}},
        '{'{T_OK, T_OK, T_OK, S_ES, S_FS, S_RR}, '{T_OK, T_OK, T_OK, T_OK, S_FR, S_RR}},
        '{'{T_OK, T_OK, T_OK, T_OK, S_FS, S_RR}, '{T_OK, T_OK, T_OK, T_OK, S_FR, S_RR}},
        '{'{T_OK, T_OK, T_OK, T_OK, T_OK, S_RR}, '{T_OK, T_OK, T_OK, S_FW, S_CL, S_RR}},
        '{'{T_OK, T_OK, T_OK, S_CW, S_CL, S_RR}, '{T_OK, T_OK, T_OK, T_OK, T_OK, S_RR}},
        '{'{T_OK, T_OK, T_OK, T_OK, S_LA, S_RR}, '{T_OK, T_OK, T_OK, T_OK, S_LA, S_RR}},
        '{'{T_OK, T_OK, T_OK, T_OK, S_LA, S_RR}, '{T_OK, T_OK, T_OK, T_OK, S_LA, S_RR}},
        '{'{T_OK, T_OK, T_OK, S_LA, T_OK, S_RR}, '{T_OK, T_OK, T_OK, S_LA, T_OK, S_RR}},
        '{'{T_OK, T_OK, T_OK, S_TW, T_OK, S_RR}, '{T_OK, T_OK, T_OK, S_TW, T_OK, S_RR}},
        '{'{T_OK, S_SS, T_OK, T_OK, T_OK, T_OK}, '{T_OK, T_OK, T_OK, T_OK, T_OK, T_OK}},
        '{'{T_OK, T_OK, T_OK, T_OK, T_OK, T_OK}, '{T_OK, T_OK, T_OK, T_OK, T_OK, T_OK}},
        '{'{T_OK, T_OK, T_OK, T_OK, T_OK, T_OK}, '{T_OK, T_OK, T_OK, T_OK, T_OK, T_OK}}
    };

    // strict mode: states refused per [direction][flag case]
    localparam logic [13:0] STRICT_MASK [2][6] = '{
        '{14'h3FFF, 14'h0000, 14'h0F93, 14'h0007, 14'h0007, 14'h0000},
        '{14'h3FFF, 14'h0F99, 14'h0001, 14'h0001, 14'h0007, 14'h0000}
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    logic     cfg_index = 1'b0;
    logic     cfg_data = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    seg_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    seg_out_t out_data;

    // predictor state
    logic        strict_on;
    logic        rst_order_on;
    logic [3:0]  conn_state [FLOWS];
    logic [31:0] side_end [2*FLOWS];
    logic [31:0] side_ack_win [2*FLOWS];
    logic [31:0] side_max_win [2*FLOWS];
    logic [3:0]  side_shift [2*FLOWS];

    seg_out_t    verdict_q [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;

    // per-flow sequence generator
    int          gen_step [POOL];
    logic [31:0] gen_next [2*POOL];

    tcp_connection_state_tracker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit seq_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    // window check with its per-side updates
    function automatic bit window_pass(seg_in_t s, int fi, int ti, logic [3:0] old_st);
        logic [7:0]         fl;
        logic [31:0]        sq;
        logic [31:0]        ak;
        logic [31:0]        wn;
        logic [31:0]        en;
        logic [3:0]         opt;
        logic signed [31:0] d32;
        longint             skew;
        fl  = s.flag_byte;
        sq  = s.seq_number;
        ak  = s.ack_number;
        en  = sq + {16'h0, s.payload_length};
        opt = (s.window_scale > 4'd14) ? 4'd14 : s.window_scale;
        if (fl[1])
            en = en + 1;
        if (fl[0])
            en = en + 1;
        wn = (s.window_field != 0) ? ({16'h0, s.window_field} << side_shift[fi]) : 32'd1;

        if ((fl & FL_CORE) == FL_SYN)
        begin
            side_end[fi]     = en;
            side_ack_win[fi] = en;
            side_max_win[fi] = wn;
            side_end[ti]     = 0;
            side_ack_win[ti] = 0;
            side_max_win[ti] = 1;
            side_shift[fi]   = opt;
            side_shift[ti]   = 4'd0;
            return 1'b1;
        end
        if ((fl & FL_CORE) == (FL_SYN | FL_ACK))
        begin
            if (side_end[ti] == 0)
                return 1'b1;
            side_end[fi]     = en;
            side_ack_win[fi] = en + 1;
            side_max_win[fi] = wn;
            side_shift[fi]   = opt;
        end
        if (side_end[fi] == 0 || side_end[ti] == 0)
            return 1'b1;

        if ((fl & FL_ACK) == 0)
            ak = side_end[ti];
        else if ((fl & FL_RST) != 0 && ak == 0)
            ak = side_end[ti];

        if ((fl & FL_RST) != 0)
        begin
            if (sq == 0 && old_st == S_SS)
            begin
                en = side_end[fi];
                sq = en;
            end
            if (rst_order_on && (side_end[fi] - sq) > 32'd1)
                return 1'b0;
        end

        if (!(en == side_ack_win[fi] || seq_before(en, side_ack_win[fi])))
            return 1'b0;
        if (seq_before(sq, side_end[fi] - side_max_win[ti]))
            return 1'b0;

        d32  = side_end[ti] - ak;
        skew = d32;
        if (skew < -longint'(ACK_SLACK) || skew > (longint'(ACK_SLACK) << side_shift[fi]))
            return 1'b0;

        if (skew < 0)
            side_end[ti] = ak;
        if (side_max_win[fi] < wn)
            side_max_win[fi] = wn;
        if (en != side_end[fi] && !seq_before(en, side_end[fi]))
            side_end[fi] = en;
        if (!seq_before(ak + wn, side_ack_win[ti]))
            side_ack_win[ti] = ak + wn;
        return 1'b1;
    endfunction

    function automatic seg_out_t track_segment(seg_in_t s);
        seg_out_t   r;
        int         flow;
        int         fi;
        int         ti;
        logic [3:0] st;
        logic [3:0] nx;
        logic [3:0] idx;
        logic [2:0] fc;
        flow = int'(s.flow_index);
        fi   = 2 * flow + int'(s.direction);
        ti   = 2 * flow + int'(s.direction ^ 1'b1);
        st   = conn_state[flow];
        idx  = {s.flag_byte[4], s.flag_byte[2:0]};
        fc   = CASE_MAP[idx*4 +: 3];
        if (st > S_RR)
            st = S_NO;
        if (fc > FC_RST)
            fc = FC_INV;
        nx = NEXT_TAB[st][s.direction][fc];
        r.verdict    = VERDICT_SAME;
        r.error_code = ERR_NONE;

        if (strict_on && st == S_NO && (s.flag_byte & FL_CORE) != FL_SYN
            && (s.flag_byte & FL_RST) == 0)
        begin
            r.verdict    = VERDICT_DROP;
            r.error_code = ERR_NEED_SYN;
        end
        else if (strict_on && STRICT_MASK[s.direction][fc][st])
        begin
            r.verdict    = VERDICT_DROP;
            r.error_code = ERR_BAD_TRAN;
        end
        else if (!window_pass(s, fi, ti, st))
        begin
            r.verdict    = VERDICT_DROP;
            r.error_code = ERR_WINDOW;
        end
        else if (nx == T_ER)
        begin
            r.verdict    = VERDICT_DROP;
            r.error_code = ERR_INVALID;
        end
        else if (nx != T_OK)
        begin
            r.verdict        = VERDICT_CHANGE;
            st               = nx;
            conn_state[flow] = nx;
        end
        r.state_after = st;
        return r;
    endfunction

    function automatic seg_in_t make_seg(int flow, bit dir, logic [7:0] flags,
                                         logic [31:0] sq, logic [31:0] ak,
                                         logic [15:0] win, logic [15:0] len,
                                         logic [3:0] scale);
        seg_in_t s;
        s.flow_index     = flow[9:0];
        s.direction      = dir;
        s.flag_byte      = flags;
        s.seq_number     = sq;
        s.ack_number     = ak;
        s.window_field   = win;
        s.payload_length = len;
        s.window_scale   = scale;
        return s;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // one segment transfer, then an optional sender gap
    task automatic send_seg(seg_in_t s);
        in_data  <= s;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        verdict_q.push_back(track_segment(s));
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_STRICT)
            strict_on = val;
        else
            rst_order_on = val;
    endtask

    task automatic set_mode(logic strict, logic rst_order);
        write_reg(REG_STRICT, strict);
        write_reg(REG_RST_ORD, rst_order);
    endtask

    // segment of one pooled connection, seq/ack tracking its two sides
    task automatic send_flow_seg(int p, bit dir, logic [7:0] flags, logic [15:0] len,
                                 bit skewed);
        logic [31:0] sq;
        int          me;
        me = 2 * p + int'(dir);
        if ((flags & FL_CORE) == FL_SYN)
            gen_next[me] = $urandom;
        sq = gen_next[me];
        if (skewed)
            sq = sq + $urandom_range(0, 400000) - 200000;
        send_seg(make_seg(p * 32 + 3, dir, flags, sq, gen_next[2 * p + int'(dir ^ 1'b1)],
                          16'($urandom_range(0, 65535)), len, 4'($urandom_range(0, 15))));
        gen_next[me] = gen_next[me] + len + flags[1] + flags[0];
    endtask

    task automatic send_random_seg();
        int   p;
        int   r;
        int   st;
        logic [15:0] len;
        bit   skewed;
        p      = $urandom_range(0, POOL - 1);
        r      = $urandom_range(99);
        skewed = ($urandom_range(99) < 10);
        len    = ($urandom_range(99) < 3) ? 16'hFFFF : 16'($urandom_range(0, 1460));
        if (r < 8)
        begin
            send_seg(make_seg(int'($urandom_range(0, FLOWS - 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), $urandom, $urandom,
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              4'($urandom_range(0, 15))));
        end
        else if (r < 14)
        begin
            if ($urandom_range(1))
                send_flow_seg(p, 1'($urandom_range(0, 1)), FL_RST | FL_ACK, 16'd0, skewed);
            else
                send_seg(make_seg(p * 32 + 3, 1'b0, FL_RST,
                                  $urandom_range(1) ? 32'h0 : gen_next[2 * p], 32'd0,
                                  16'($urandom_range(0, 65535)), 16'd0, 4'd0));
        end
        else
        begin
            st = gen_step[p];
            case (st)
                0:       send_flow_seg(p, 1'b0, FL_SYN, 16'd0, 1'b0);
                1:
                begin
                    gen_next[2 * p + 1] = $urandom;
                    send_flow_seg(p, 1'b1, FL_SYN | FL_ACK, 16'd0, skewed);
                end
                2:       send_flow_seg(p, 1'b0, FL_ACK, 16'd0, skewed);
                3, 4, 5, 6:
                         send_flow_seg(p, 1'($urandom_range(0, 1)), FL_ACK, len, skewed);
                7:       send_flow_seg(p, 1'b0, FL_FIN | FL_ACK, 16'd0, skewed);
                8:       send_flow_seg(p, 1'b1, FL_ACK, 16'd0, skewed);
                9:       send_flow_seg(p, 1'b1, FL_FIN | FL_ACK, 16'd0, skewed);
                default: send_flow_seg(p, 1'b0, FL_ACK, 16'd0, skewed);
            endcase
            gen_step[p] = (st >= 10) ? 0 : st + 1;
        end
    endtask

    // check each result transfer and drive the result-side stall
    always @(posedge clk)
    begin
        seg_out_t want;
        if (out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                report_mismatch("outstanding results", 1, 0);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_data.verdict != want.verdict)
                    report_mismatch("verdict", out_data.verdict, want.verdict);
                if (out_data.state_after != want.state_after)
                    report_mismatch("state_after", out_data.state_after, want.state_after);
                if (out_data.error_code != want.error_code)
                    report_mismatch("error_code", out_data.error_code, want.error_code);
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog over cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // connection life cycles, extremes and corner cases, relaxed mode
    task automatic test_directed_relaxed();
        send_seg(make_seg(0, 1'b0, FL_SYN, 32'hFFFF_FFF0, 0, 16'hFFFF, 0, 4'd15));
        send_seg(make_seg(0, 1'b1, FL_SYN | FL_ACK, 32'h1000, 32'hFFFF_FFF1, 16'hFFFF, 0, 4'd14));
        send_seg(make_seg(0, 1'b0, FL_ACK, 32'hFFFF_FFF1, 32'h1001, 16'h0, 0, 0));
        send_seg(make_seg(0, 1'b0, FL_ACK, 32'hFFFF_FFF1, 32'h1001, 16'h100, 16'hFFFF, 0));
        send_seg(make_seg(0, 1'b0, FL_FIN | FL_ACK, 32'h0000_FFF0, 32'h1001, 16'h100, 0, 0));
        send_seg(make_seg(0, 1'b1, FL_ACK, 32'h1001, 32'h0000_FFF1, 16'h100, 0, 0));
        send_seg(make_seg(0, 1'b1, FL_FIN | FL_ACK, 32'h1001, 32'h0000_FFF1, 16'h100, 0, 0));
        send_seg(make_seg(0, 1'b0, FL_ACK, 32'h0000_FFF1, 32'h1002, 16'h100, 0, 0));
        // invalid flags on fresh flows
        send_seg(make_seg(1023, 1'b0, 8'h00, 0, 0, 0, 0, 0));
        send_seg(make_seg(1022, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                          16'hFFFF, 4'd15));
        send_seg(make_seg(1021, 1'b0, 8'hE8, 0, 0, 0, 0, 0));
        // reply side opened, initiator SYN-ACK dropped on the ack, state still none
        send_seg(make_seg(7, 1'b1, FL_SYN, 32'd1000, 0, 16'd5000, 0, 0));
        send_seg(make_seg(7, 1'b0, FL_SYN | FL_ACK, 32'd9000, 32'h8000_0000, 16'd5000, 0, 0));
        send_seg(make_seg(7, 1'b0, 8'h00, 32'd9001, 0, 16'd5000, 0, 0));
        send_seg(make_seg(7, 1'b0, 8'h00, 32'h9000_0000, 0, 16'd5000, 0, 0));
        // RST with zero sequence after the SYN and SYN-ACK
        send_seg(make_seg(9, 1'b0, FL_SYN, 32'd500, 0, 16'd100, 0, 3));
        send_seg(make_seg(9, 1'b1, FL_SYN | FL_ACK, 32'd70, 32'd501, 16'd100, 0, 3));
        send_seg(make_seg(9, 1'b0, FL_RST, 0, 0, 16'd100, 0, 0));
        send_seg(make_seg(11, 1'b0, FL_RST | FL_ACK, 0, 0, 16'd1, 0, 0));
    endtask

    // strict creation rule, refused transitions and RST ordering
    task automatic test_directed_strict();
        send_seg(make_seg(20, 1'b0, FL_ACK, 32'd1, 32'd1, 16'd10, 0, 0));
        send_seg(make_seg(21, 1'b1, FL_SYN, 32'd1, 0, 16'd10, 0, 0));
        send_seg(make_seg(22, 1'b0, FL_SYN, 32'd100, 0, 16'd1000, 0, 2));
        send_seg(make_seg(22, 1'b1, FL_ACK, 32'd900, 32'd101, 16'd1000, 0, 0));
        send_seg(make_seg(22, 1'b1, FL_SYN | FL_ACK, 32'd900, 32'd101, 16'd1000, 0, 1));
        send_seg(make_seg(22, 1'b0, FL_SYN | FL_ACK, 32'd101, 32'd901, 16'd1000, 0, 0));
        send_seg(make_seg(22, 1'b0, FL_RST, 32'd50, 32'd901, 16'd1000, 0, 0));
        send_seg(make_seg(22, 1'b0, FL_RST, 32'd100, 32'd901, 16'd1000, 0, 0));
        send_seg(make_seg(23, 1'b0, FL_RST, 32'd7, 0, 16'd1, 0, 0));
    endtask

    task automatic test_random(int segs, int sidle, int rstall, bit pressure);
        send_idle_pct = sidle;
        stall_pct     = rstall;
        for (int i = 0; i < segs; i++)
        begin
            send_random_seg();
            if (pressure && i % 100 == 50)
                wait_drained();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial
    begin
        strict_on    = 1'b0;
        rst_order_on = 1'b0;
        for (int i = 0; i < FLOWS; i++)
            conn_state[i] = S_NO;
        for (int i = 0; i < 2 * FLOWS; i++)
        begin
            side_end[i]     = 0;
            side_ack_win[i] = 0;
            side_max_win[i] = 0;
            side_shift[i]   = 4'd0;
        end
        for (int i = 0; i < POOL; i++)
            gen_step[i] = 0;
        for (int i = 0; i < 2 * POOL; i++)
            gen_next[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_relaxed();
        set_mode(1'b1, 1'b1);
        test_directed_strict();

        set_mode(1'b0, 1'b0);
        test_random(PHASE_SEGS, 0, 0, 1'b0);
        set_mode(1'b1, 1'b0);
        test_random(PHASE_SEGS, 62, 0, 1'b0);
        set_mode(1'b1, 1'b1);
        test_random(PHASE_SEGS, 0, 62, 1'b1);
        set_mode(1'b0, 1'b1);
        test_random(PHASE_SEGS, 16, 16, 1'b0);
        set_mode(1'b0, 1'b0);
        test_random(PHASE_SEGS, 0, 0, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
